// ===== rtl/aesctr_pkg.sv =====
// Shared types, constants and functions for the AES-256 CTR encryptor.
`timescale 1ns / 1ps
package aesctr_pkg;

  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RND_W   = 4;
  localparam logic [RND_W-1:0] LAST_ROUND = 4'd14;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_L = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_H = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_END = 3'd7;

  typedef logic [7:0][WORD_W-1:0] key_win_t;
  typedef logic [3:0][WORD_W-1:0] key_quad_t;

  typedef struct packed {
    logic load;
    logic step;
    logic last_round;
    logic out_load;
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = 8'h01;
      3'd1: v = 8'h02;
      3'd2: v = 8'h04;
      3'd3: v = 8'h08;
      3'd4: v = 8'h10;
      3'd5: v = 8'h20;
      3'd6: v = 8'h40;
      default: v = 8'h00;
    endcase
    rcon = v;
  endfunction

  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [WORD_W-1:0] ctr_add(input logic [WORD_W-1:0] v,
                                                input logic [WORD_W-1:0] a,
                                                input logic be);
    ctr_add = be ? swap32(swap32(v) + a) : (v + a);
  endfunction

endpackage

// ===== rtl/aesctr_in_if.sv =====
// Input block channel: valid/ready with plaintext payload.
`timescale 1ns / 1ps
interface aesctr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic        last_block;

  modport source (output valid, data_low, data_high, last_block, input ready);
  modport sink   (input valid, data_low, data_high, last_block, output ready);
endinterface

// ===== rtl/aesctr_out_if.sv =====
// Result channel: valid/ready with ciphertext payload.
`timescale 1ns / 1ps
interface aesctr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_low;
  logic [63:0] cipher_high;

  modport source (output valid, cipher_low, cipher_high, input ready);
  modport sink   (input valid, cipher_low, cipher_high, output ready);
endinterface

// ===== rtl/aesctr_ctrl.sv =====
// Round sequencer and handshake control for the AES-256 CTR encryptor.
`timescale 1ns / 1ps
module aesctr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output aesctr_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [aesctr_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic                         oval_r, oval_nxt;
  logic                         slot_free;

  assign slot_free = !oval_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = oval_r;

  always_comb begin
    state_nxt      = state_r;
    rnd_nxt        = rnd_r;
    oval_nxt       = oval_r && !out_ready;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          rnd_nxt   = aesctr_pkg::RND_W'(1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (rnd_r == aesctr_pkg::LAST_ROUND) begin
          cmd.last_round = 1'b1;
          state_nxt      = ST_FIN;
        end else begin
          rnd_nxt = rnd_r + aesctr_pkg::RND_W'(1);
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          oval_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

// ===== rtl/aesctr_dp.sv =====
// Datapath: config registers, counter, shared AES round and on-the-fly key schedule.
`timescale 1ns / 1ps
module aesctr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  aesctr_pkg::dp_cmd_t                 cmd,
  input  logic                                cfg_we,
  input  logic [aesctr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aesctr_pkg::CFG_W-1:0]        cfg_data,
  input  logic [63:0]                         in_lo,
  input  logic [63:0]                         in_hi,
  input  logic                                in_last,
  output logic [63:0]                         out_lo,
  output logic [63:0]                         out_hi
);

  logic [63:0] key_a_r, key_b_r, key_c_r, key_d_r, nonce_l_r, nonce_h_r;
  logic [31:0] offset_r, ctr_r, ctr_nxt;
  logic        be_r;
  logic [127:0] st_r, st_nxt, pt_r, res_r;
  aesctr_pkg::key_win_t win_r, win_nxt, key_words;
  logic [aesctr_pkg::RND_W-1:0] rnd_r;
  logic [255:0] key_bytes;
  logic [127:0] ctr_blk, rk0, rkr, rnd_out;
  logic [63:0]  nh_sel;
  logic [31:0]  off_sel;
  logic         be_sel;

  function automatic aesctr_pkg::key_quad_t gen(input aesctr_pkg::key_win_t w,
                                                input logic [3:0] r);
    logic [31:0] t;
    aesctr_pkg::key_quad_t n;
    t = w[7];
    if (!r[0]) t = aesctr_pkg::sub_word({t[23:0], t[31:24]}) ^ {aesctr_pkg::rcon(r[3:1]), 24'h0};
    else t = aesctr_pkg::sub_word(t);
    n[0] = w[0] ^ t;
    n[1] = w[1] ^ n[0];
    n[2] = w[2] ^ n[1];
    n[3] = w[3] ^ n[2];
    gen = n;
  endfunction

  // round key as AES state bytes: byte 4c+r from word c, row r
  function automatic logic [127:0] rk_bytes(input aesctr_pkg::key_win_t w);
    logic [127:0] v;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        v[8*(4*c+r) +: 8] = w[c][31-8*r -: 8];
    rk_bytes = v;
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
    logic [127:0] t, m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[8*(4*c+r) +: 8] = aesctr_pkg::SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c)   +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      m[8*(4*c)   +: 8] = aesctr_pkg::xt(a0) ^ aesctr_pkg::xt(a1) ^ a1 ^ a2 ^ a3;
      m[8*(4*c+1) +: 8] = a0 ^ aesctr_pkg::xt(a1) ^ aesctr_pkg::xt(a2) ^ a2 ^ a3;
      m[8*(4*c+2) +: 8] = a0 ^ a1 ^ aesctr_pkg::xt(a2) ^ aesctr_pkg::xt(a3) ^ a3;
      m[8*(4*c+3) +: 8] = aesctr_pkg::xt(a0) ^ a0 ^ a1 ^ a2 ^ aesctr_pkg::xt(a3);
    end
    aes_round = fin ? t : m;
  endfunction

  assign key_bytes = {key_d_r, key_c_r, key_b_r, key_a_r};

  always_comb begin
    for (int i = 0; i < 8; i++)
      for (int b = 0; b < 4; b++)
        key_words[i][31-8*b -: 8] = key_bytes[8*(4*i+b) +: 8];
  end

  assign ctr_blk = {ctr_r, nonce_h_r[31:0], nonce_l_r};
  assign rk0     = rk_bytes(key_words);
  assign rkr     = rk_bytes(win_r);
  assign rnd_out = aes_round(st_r, cmd.last_round) ^ rkr;

  always_comb begin
    win_nxt = win_r;
    st_nxt  = st_r;
    if (cmd.load) begin
      st_nxt       = ctr_blk ^ rk0;
      win_nxt[3:0] = key_words[7:4];
      win_nxt[7:4] = gen(key_words, 4'd0);
    end else if (cmd.step) begin
      st_nxt       = cmd.last_round ? (rnd_out ^ pt_r) : rnd_out;
      win_nxt[3:0] = win_r[7:4];
      win_nxt[7:4] = gen(win_r, rnd_r);
    end
  end

  // counter settings as they stand after this cycle's write
  always_comb begin
    nh_sel  = nonce_h_r;
    off_sel = offset_r;
    be_sel  = be_r;
    ctr_nxt = ctr_r;
    if (cfg_we && cfg_index == aesctr_pkg::REG_NONCE_H) nh_sel = cfg_data;
    if (cfg_we && cfg_index == aesctr_pkg::REG_OFFSET)  off_sel = cfg_data[31:0];
    if (cfg_we && cfg_index == aesctr_pkg::REG_BIG_END) be_sel = cfg_data[0];
    if (cfg_we && (cfg_index == aesctr_pkg::REG_NONCE_H || cfg_index == aesctr_pkg::REG_OFFSET ||
                   cfg_index == aesctr_pkg::REG_BIG_END)) begin
      ctr_nxt = aesctr_pkg::ctr_add(nh_sel[63:32], off_sel, be_sel);
    end else if (cmd.load) begin
      ctr_nxt = in_last ? aesctr_pkg::ctr_add(nonce_h_r[63:32], offset_r, be_r)
                        : aesctr_pkg::ctr_add(ctr_r, 32'd1, be_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r   <= '0;
      key_b_r   <= '0;
      key_c_r   <= '0;
      key_d_r   <= '0;
      nonce_l_r <= '0;
      nonce_h_r <= '0;
      offset_r  <= '0;
      be_r      <= 1'b0;
      ctr_r     <= '0;
      rnd_r     <= '0;
    end else begin
      ctr_r     <= ctr_nxt;
      nonce_h_r <= nh_sel;
      offset_r  <= off_sel;
      be_r      <= be_sel;
      if (cfg_we && cfg_index == aesctr_pkg::REG_KEY_A)   key_a_r   <= cfg_data;
      if (cfg_we && cfg_index == aesctr_pkg::REG_KEY_B)   key_b_r   <= cfg_data;
      if (cfg_we && cfg_index == aesctr_pkg::REG_KEY_C)   key_c_r   <= cfg_data;
      if (cfg_we && cfg_index == aesctr_pkg::REG_KEY_D)   key_d_r   <= cfg_data;
      if (cfg_we && cfg_index == aesctr_pkg::REG_NONCE_L) nonce_l_r <= cfg_data;
      if (cmd.load)      rnd_r <= 4'd1;
      else if (cmd.step) rnd_r <= rnd_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    st_r  <= st_nxt;
    win_r <= win_nxt;
    if (cmd.load)     pt_r  <= {in_hi, in_lo};
    if (cmd.out_load) res_r <= st_r;
  end

  assign out_lo = res_r[63:0];
  assign out_hi = res_r[127:64];

endmodule

// ===== rtl/aes256_ctr_encryptor_unit.sv =====
// Top level of the AES-256 counter-mode encryptor.
// One 128-bit block per transfer: a load, fourteen rounds of the single shared AES round
// (round keys generated alongside, four words a cycle), then an output register load that
// waits while that register holds an unread result. A new block is taken once the previous
// one has reached the output register. The user must write key and counter registers via
// the cfg port only while idle (not enforced); a key write takes effect for the next block.
`timescale 1ns / 1ps
module aes256_ctr_encryptor_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  aesctr_in_if.sink                        in_ch,
  aesctr_out_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [aesctr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aesctr_pkg::CFG_W-1:0]     cfg_data
);

  aesctr_pkg::dp_cmd_t cmd;

  aesctr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  aesctr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_lo     (in_ch.data_low),
    .in_hi     (in_ch.data_high),
    .in_last   (in_ch.last_block),
    .out_lo    (out_ch.cipher_low),
    .out_hi    (out_ch.cipher_high)
  );

`ifndef NO_ASSERTIONS
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a block is in flight");

  a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> ##14 cmd.last_round)
    else $error("final round not reached after fourteen rounds");

  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten before transfer");
`endif

endmodule
